// File: hw/rtl/htw_pkg.sv
`default_nettype none
package htw_pkg;
	localparam int unsigned OP_W = 2;
	localparam int unsigned TO_W = 32;
	localparam int unsigned ID_W = 5;
	localparam int unsigned ST_W = 2;

	// wheel size; a power of two so the slot index wraps on its own
	localparam int unsigned SLOTS = 64;
	localparam int unsigned SL_W  = $clog2(SLOTS);

	typedef enum logic [OP_W-1:0] {
		OP_ADD  = 2'd0,
		OP_DEL  = 2'd1,
		OP_TICK = 2'd2,
		OP_NOP  = 2'd3
	} op_t;

	typedef enum logic [ST_W-1:0] {
		ST_OK      = 2'd0,
		ST_NEG     = 2'd1,
		ST_FULL    = 2'd2,
		ST_BAD_HDL = 2'd3
	} status_t;

	// one item handed from the front end to the back end
	typedef struct packed {
		op_t               op;
		logic [TO_W-1:0]   timeout;
		logic [ID_W-1:0]   handle;
	} cmd_t;

	// one result item
	typedef struct packed {
		logic [ID_W-1:0] timer_id;
		status_t         status;
		logic            expired;
		logic            last;
	} res_t;
endpackage
`default_nettype wire

// File: hw/rtl/hashed_timing_wheel_core.sv
// Hashed timing wheel of 64 slots with a pool of min(POOL,32) timers. Op 0
// adds a timer (returns handle), op 1 deletes one, op 2 advances the wheel one
// tick and reports every expired timer in ascending handle order, one transfer
// per expiry, the final one marked in tlast; with no expiry it gives a single
// transfer with tlast set. The sequencer takes one command at a time: an add
// steps through accept, two multiply steps that divide by TICK_UNIT through a
// reciprocal, store and result transfer; a tick scans one entry per cycle while
// no expiry is being emitted and the result side does not stall. It takes no
// new command while the result side stalls. A two-entry queue decouples the
// input from the sequencer and registers each command on its way to it.
`default_nettype none
module hashed_timing_wheel_core
	import htw_pkg::*;
#(
	parameter int unsigned TICK_UNIT = 10,
	parameter int unsigned POOL      = 32
)(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [39:0] s_tdata,  // op[1:0], timeout[33:2], handle[38:34], pad
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [7:0]       m_tdata,  // timer_id[4:0], status[6:5], pad
	output logic             m_tuser,  // expired
	output logic             m_tlast
);
	cmd_t in_cmd, q_cmd;
	logic q_valid, q_ready;
	res_t res;

	assign in_cmd.op      = op_t'(s_tdata[1:0]);
	assign in_cmd.timeout = s_tdata[33:2];
	assign in_cmd.handle  = s_tdata[38:34];

	htw_front u_front (
		.clk, .arst_n,
		.in_valid(s_tvalid), .in_ready(s_tready), .in_cmd,
		.q_valid, .q_ready, .q_cmd
	);

	htw_back #(.TICK_UNIT(TICK_UNIT), .POOL(POOL)) u_back (
		.clk, .arst_n,
		.c_valid(q_valid), .c_ready(q_ready), .c_cmd(q_cmd),
		.r_valid(m_tvalid), .r_ready(m_tready), .r_res(res)
	);

	assign m_tdata = {1'b0, res.status, res.timer_id};
	assign m_tuser = res.expired;
	assign m_tlast = res.last;
endmodule
`default_nettype wire

// File: hw/rtl/htw_front.sv
`default_nettype none
module htw_front
	import htw_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output logic      in_ready,
	input  wire cmd_t in_cmd,
	output logic      q_valid,
	input  wire logic q_ready,
	output cmd_t      q_cmd
);
	// two-entry queue between the input and the back end
	cmd_t     mem_q [2];
	logic     wr_q, rd_q;
	logic [1:0] cnt_q;
	logic     push, pop;

	assign in_ready = (cnt_q != 2'd2);
	assign q_valid  = (cnt_q != 2'd0);
	assign q_cmd    = mem_q[rd_q];
	assign push     = in_valid && in_ready;
	assign pop      = q_valid && q_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wr_q <= ~wr_q;
			if (pop) rd_q <= ~rd_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

	// store payload
	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= in_cmd;
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= 2'd2) else $error("queue overfilled");
	assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == 2'd0) |-> !pop) else $error("pop from empty queue");
	assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == 2'd2) |-> !push) else $error("push into full queue");
	assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> (cnt_q == $past(cnt_q) + 2'd1)) else $error("count slip");
endmodule
`default_nettype wire

// File: hw/rtl/htw_back.sv
`default_nettype none
module htw_back
	import htw_pkg::*;
#(
	parameter int unsigned TICK_UNIT = 10,
	parameter int unsigned POOL      = 32
)(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic c_valid,
	output logic      c_ready,
	input  wire cmd_t c_cmd,
	output logic      r_valid,
	input  wire logic r_ready,
	output res_t      r_res
);
	localparam int unsigned USABLE = (POOL < 32) ? POOL : 32;
	localparam int unsigned UI_W   = (USABLE > 1) ? $clog2(USABLE) : 1;
	localparam int unsigned CT_W   = $clog2(USABLE + 1);
	localparam int unsigned ACC_W  = 2 * TO_W;
	localparam int unsigned HALF_W = TO_W / 2;
	// timeout / TICK_UNIT == (timeout * RECIP) >> RSH for every non-negative timeout
	localparam int unsigned TU_L   = $clog2(TICK_UNIT);
	localparam int unsigned RSH    = TO_W - 1 + TU_L;
	localparam logic [ACC_W-1:0] RECIP_W =
		((ACC_W'(1) << RSH) + ACC_W'(TICK_UNIT) - ACC_W'(1)) / ACC_W'(TICK_UNIT);
	localparam logic [TO_W-1:0] RECIP = RECIP_W[TO_W-1:0];

	typedef enum logic [2:0] {
		S_IDLE, S_MUL_LO, S_MUL_HI, S_ADD, S_SCAN, S_EMIT, S_OUT
	} state_t;
	state_t state_q;

	logic [USABLE-1:0] used_q;
	logic [TO_W-1:0]   rounds_q [USABLE];
	logic [SL_W-1:0]   slot_q   [USABLE];
	logic [SL_W-1:0]   cur_q;
	logic [UI_W-1:0]   free_q;
	logic [TO_W-1:0]   arg_q;
	logic [ACC_W-1:0]  acc_q;
	logic [CT_W-1:0]   scan_q;
	logic              hit_q;
	res_t              res_q;
	logic              rv_q;

	logic [UI_W-1:0]        free_idx;
	logic                   any_free;
	logic [HALF_W-1:0]      mul_b;
	logic [TO_W+HALF_W-1:0] part;
	logic [TO_W-1:0]        quo;
	logic [TO_W-1:0]        ticks;
	logic [UI_W-1:0]        sidx;
	logic                   hidx_ok;

	// lowest free entry
	always_comb begin
		free_idx = '0;
		any_free = 1'b0;
		for (int i = USABLE - 1; i >= 0; i--) begin
			if (!used_q[i]) begin
				free_idx = UI_W'(i);
				any_free = 1'b1;
			end
		end
	end

	// one half of the reciprocal per multiply step
	assign mul_b   = (state_q == S_MUL_HI) ? RECIP[TO_W-1:HALF_W] : RECIP[HALF_W-1:0];
	assign part    = {{HALF_W{1'b0}}, arg_q} * {{TO_W{1'b0}}, mul_b};
	assign quo     = TO_W'(acc_q >> RSH);
	assign ticks   = (quo == '0) ? TO_W'(1) : quo;
	assign sidx    = scan_q[UI_W-1:0];
	assign hidx_ok = ({27'd0, c_cmd.handle} < 32'(USABLE));
	assign c_ready = (state_q == S_IDLE) && !rv_q;
	assign r_valid = rv_q;
	assign r_res   = res_q;

	// sequencer: reciprocal multiply for add, one entry per cycle for tick while no expiry or stalled result holds it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			used_q  <= '0;
			cur_q   <= '0;
			rv_q    <= 1'b0;
			hit_q   <= 1'b0;
			scan_q  <= '0;
			free_q  <= '0;
			arg_q   <= '0;
			acc_q   <= '0;
			res_q   <= '0;
			for (int i = 0; i < USABLE; i++) begin
				rounds_q[i] <= '0;
				slot_q[i]   <= '0;
			end
		end else begin
			if (rv_q && r_ready) rv_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (c_valid && c_ready) begin
						case (c_cmd.op)
							OP_ADD: begin
								if (c_cmd.timeout[TO_W-1]) begin
									res_q <= '{timer_id: '0, status: ST_NEG,
									           expired: 1'b0, last: 1'b1};
									rv_q <= 1'b1;
								end else if (!any_free) begin
									res_q <= '{timer_id: '0, status: ST_FULL,
									           expired: 1'b0, last: 1'b1};
									rv_q <= 1'b1;
								end else begin
									free_q  <= free_idx;
									arg_q   <= c_cmd.timeout;
									state_q <= S_MUL_LO;
								end
							end
							OP_DEL: begin
								if (!hidx_ok || !used_q[c_cmd.handle[UI_W-1:0]]) begin
									res_q <= '{timer_id: c_cmd.handle, status: ST_BAD_HDL,
									           expired: 1'b0, last: 1'b1};
								end else begin
									used_q[c_cmd.handle[UI_W-1:0]] <= 1'b0;
									res_q <= '{timer_id: c_cmd.handle, status: ST_OK,
									           expired: 1'b0, last: 1'b1};
								end
								rv_q <= 1'b1;
							end
							OP_TICK: begin
								scan_q <= '0;
								hit_q  <= 1'b0;
								state_q <= S_SCAN;
							end
							default: begin
								res_q <= '{timer_id: '0, status: ST_OK,
								           expired: 1'b0, last: 1'b1};
								rv_q <= 1'b1;
							end
						endcase
					end
				end
				S_MUL_LO: begin
					acc_q   <= {{HALF_W{1'b0}}, part};
					state_q <= S_MUL_HI;
				end
				S_MUL_HI: begin
					acc_q   <= acc_q + {part, {HALF_W{1'b0}}};
					state_q <= S_ADD;
				end
				S_ADD: begin
					used_q[free_q]   <= 1'b1;
					rounds_q[free_q] <= ticks >> SL_W;
					slot_q[free_q]   <= cur_q + ticks[SL_W-1:0];
					res_q <= '{timer_id: ID_W'(free_q), status: ST_OK,
					           expired: 1'b0, last: 1'b1};
					rv_q    <= 1'b1;
					state_q <= S_IDLE;
				end
				S_SCAN: begin
					if (scan_q == CT_W'(USABLE)) begin
						cur_q <= cur_q + SL_W'(1);
						if (hit_q) begin
							res_q.last <= 1'b1;
							state_q <= S_OUT;
						end else begin
							res_q <= '{timer_id: '0, status: ST_OK, expired: 1'b0, last: 1'b1};
							rv_q  <= 1'b1;
							state_q <= S_IDLE;
						end
					end else if (used_q[sidx] && slot_q[sidx] == cur_q) begin
						if (rounds_q[sidx] != '0) begin
							rounds_q[sidx] <= rounds_q[sidx] - TO_W'(1);
							scan_q <= scan_q + CT_W'(1);
						end else if (!hit_q || !rv_q) begin
							// hold back the previous hit until the new one is known
							if (hit_q) rv_q <= 1'b1;
							used_q[sidx] <= 1'b0;
							hit_q <= 1'b1;
							scan_q <= scan_q + CT_W'(1);
							state_q <= S_EMIT;
						end
					end else begin
						scan_q <= scan_q + CT_W'(1);
					end
				end
				S_EMIT: begin
					if (!rv_q) begin
						res_q <= '{timer_id: ID_W'(sidx - UI_W'(1)), status: ST_OK,
						           expired: 1'b1, last: 1'b0};
						state_q <= S_SCAN;
					end
				end
				S_OUT: begin
					if (!rv_q) begin
						rv_q <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		(rv_q && !r_ready) |=> (rv_q && r_res == $past(r_res))) else $error("result lost");
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_ADD) |=> used_q[$past(free_q)]) else $error("add did not allocate");
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EMIT && !rv_q) |=> !used_q[$past(sidx) - UI_W'(1)])
		else $error("expired entry still used");
endmodule
`default_nettype wire

// File: tb/hashed_timing_wheel_core_test.sv
`default_nettype none
module hashed_timing_wheel_core_test
	import htw_pkg::*;
();
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned TICK_UNIT = 10;
	localparam int unsigned POOL      = 32;
	localparam int unsigned USABLE    = (POOL < 32) ? POOL : 32;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [39:0] s_tdata;   // op[1:0], timeout[33:2], handle[38:34], pad
	logic        m_tvalid;
	logic        m_tready;
	logic [7:0]  m_tdata;   // timer_id[4:0], status[6:5], pad
	logic        m_tuser;   // expired
	logic        m_tlast;

	hashed_timing_wheel_core #(.TICK_UNIT(TICK_UNIT), .POOL(POOL)) dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.m_tuser(m_tuser), .m_tlast(m_tlast)
	);

	typedef struct {
		op_t         op;
		logic [31:0] timeout;
		logic [4:0]  handle;
		logic        fixed;     // expected result typed in
		res_t        res;
	} stim_t;

	// wheel state mirror
	logic        used_q [32];
	logic [31:0] rounds_q [32];
	logic [5:0]  slot_q [32];
	logic [5:0]  wheel_pos;

	res_t   pending_q[$];
	int     mismatches;
	int     results_seen;
	int     expiries_seen;
	int     items_sent;
	logic   idle_free;   // stretch with no idling

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#5ms;
		$display("** hashed_timing_wheel_core: FAILED **");
		$finish;
	end

	function automatic res_t mk_res(logic [4:0] id, status_t st, logic ex, logic lst);
		res_t r;
		r.timer_id = id;
		r.status   = st;
		r.expired  = ex;
		r.last     = lst;
		return r;
	endfunction

	// advance the mirror and queue the results one command gives
	task automatic predict_wheel(op_t op, logic [31:0] tmo, logic [4:0] hdl);
		int          found;
		int          n;
		logic [31:0] ticks;
		case (op)
			OP_ADD: begin
				if (tmo[31]) begin
					pending_q.push_back(mk_res(5'd0, ST_NEG, 1'b0, 1'b1));
				end else begin
					found = -1;
					for (int i = 0; i < USABLE; i++)
						if (!used_q[i] && found < 0) found = i;
					if (found < 0) begin
						pending_q.push_back(mk_res(5'd0, ST_FULL, 1'b0, 1'b1));
					end else begin
						ticks = (tmo < TICK_UNIT) ? 32'd1 : tmo / TICK_UNIT;
						used_q[found]   = 1'b1;
						rounds_q[found] = ticks / SLOTS;
						slot_q[found]   = 6'((wheel_pos + ticks % SLOTS) % SLOTS);
						pending_q.push_back(mk_res(5'(found), ST_OK, 1'b0, 1'b1));
					end
				end
			end
			OP_DEL: begin
				if (hdl >= USABLE || !used_q[hdl]) begin
					pending_q.push_back(mk_res(hdl, ST_BAD_HDL, 1'b0, 1'b1));
				end else begin
					used_q[hdl] = 1'b0;
					pending_q.push_back(mk_res(hdl, ST_OK, 1'b0, 1'b1));
				end
			end
			OP_TICK: begin
				n = 0;
				for (int i = 0; i < USABLE; i++) begin
					if (used_q[i] && slot_q[i] == wheel_pos) begin
						if (rounds_q[i] > 0) begin
							rounds_q[i]--;
						end else begin
							used_q[i] = 1'b0;
							pending_q.push_back(mk_res(5'(i), ST_OK, 1'b1, 1'b0));
							n++;
						end
					end
				end
				wheel_pos = 6'((wheel_pos + 1) % SLOTS);
				if (n == 0)
					pending_q.push_back(mk_res(5'd0, ST_OK, 1'b0, 1'b1));
				else
					pending_q[$].last = 1'b1;
			end
			default: begin
				pending_q.push_back(mk_res(5'd0, ST_OK, 1'b0, 1'b0));
				pending_q[$].last = 1'b1;
			end
		endcase
	endtask

	// present one command and hold it until the transfer
	task automatic send_cmd(op_t op, logic [31:0] tmo, logic [4:0] hdl);
		while (!idle_free && $urandom_range(99) < 11) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {1'b0, hdl, tmo, op};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		items_sent++;
		@(negedge clk);
	endtask

	task automatic drive_cmd(op_t op, logic [31:0] tmo, logic [4:0] hdl);
		predict_wheel(op, tmo, hdl);
		send_cmd(op, tmo, hdl);
	endtask

	// receiver stalls
	always @(negedge clk) begin
		if (!arst_n)
			m_tready <= 1'b0;
		else
			m_tready <= idle_free || ($urandom_range(99) >= 11);
	end

	// compare each result transfer with the oldest expectation
	always @(posedge clk) begin
		res_t want;
		res_t got;
		if (arst_n && m_tvalid && m_tready) begin
			got = mk_res(m_tdata[4:0], status_t'(m_tdata[6:5]), m_tuser, m_tlast);
			results_seen++;
			if (got.expired) expiries_seen++;
			if (pending_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result: id %0d st %0d exp %0b last %0b",
						got.timer_id, got.status, got.expired, got.last);
			end else begin
				want = pending_q.pop_front();
				if (got !== want) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: want %0d/%0d/%0b/%0b, got %0d/%0d/%0b/%0b",
							want.timer_id, want.status, want.expired, want.last,
							got.timer_id, got.status, got.expired, got.last);
				end
			end
		end
	end

	stim_t dir_tab[$];

	function automatic stim_t row(op_t op, logic [31:0] tmo, logic [4:0] hdl,
			logic fixed = 1'b0, res_t res = '0);
		stim_t s;
		s.op = op; s.timeout = tmo; s.handle = hdl; s.fixed = fixed; s.res = res;
		return s;
	endfunction

	initial begin
		int   kind;
		int   n_live;
		logic [31:0] tmo;
		arst_n     = 1'b0;
		s_tvalid   = 1'b0;
		s_tdata    = '0;
		m_tready   = 1'b0;
		idle_free  = 1'b0;
		mismatches = 0;
		results_seen = 0;
		expiries_seen = 0;
		items_sent = 0;
		wheel_pos  = '0;
		for (int i = 0; i < 32; i++) begin
			used_q[i] = 1'b0; rounds_q[i] = '0; slot_q[i] = '0;
		end
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed rows: extremes, every op and each error case
		dir_tab.push_back(row(OP_TICK, 32'd0, 5'd0, 1'b1, mk_res(5'd0, ST_OK, 1'b0, 1'b1)));
		dir_tab.push_back(row(OP_DEL, 32'd0, 5'd0, 1'b1, mk_res(5'd0, ST_BAD_HDL, 1'b0, 1'b1)));
		dir_tab.push_back(row(OP_DEL, 32'd0, 5'd31, 1'b1, mk_res(5'd31, ST_BAD_HDL, 1'b0, 1'b1)));
		dir_tab.push_back(row(OP_ADD, 32'h8000_0000, 5'd0, 1'b1, mk_res(5'd0, ST_NEG, 1'b0, 1'b1)));
		dir_tab.push_back(row(OP_ADD, 32'hFFFF_FFFF, 5'd31, 1'b1, mk_res(5'd0, ST_NEG, 1'b0, 1'b1)));
		dir_tab.push_back(row(OP_NOP, 32'hFFFF_FFFF, 5'd31, 1'b1, mk_res(5'd0, ST_OK, 1'b0, 1'b1)));
		dir_tab.push_back(row(OP_ADD, 32'd0, 5'd0, 1'b1, mk_res(5'd0, ST_OK, 1'b0, 1'b1)));
		dir_tab.push_back(row(OP_ADD, 32'd9, 5'd0));
		dir_tab.push_back(row(OP_ADD, 32'd10, 5'd0));
		dir_tab.push_back(row(OP_ADD, 32'd640, 5'd0));
		dir_tab.push_back(row(OP_ADD, 32'h7FFF_FFFF, 5'd0));
		dir_tab.push_back(row(OP_TICK, 32'd0, 5'd0));
		dir_tab.push_back(row(OP_TICK, 32'd0, 5'd0));
		dir_tab.push_back(row(OP_DEL, 32'd0, 5'd4));
		dir_tab.push_back(row(OP_DEL, 32'd0, 5'd4));
		// fill the pool, then overflow it
		for (int i = 0; i < 33; i++)
			dir_tab.push_back(row(OP_ADD, 32'd5 + 32'(i) * 10, 5'd0));
		foreach (dir_tab[k]) begin
			if (dir_tab[k].fixed) begin
				pending_q.push_back(dir_tab[k].res);
				predict_wheel(dir_tab[k].op, dir_tab[k].timeout, dir_tab[k].handle);
				void'(pending_q.pop_back());
			end else begin
				predict_wheel(dir_tab[k].op, dir_tab[k].timeout, dir_tab[k].handle);
			end
			send_cmd(dir_tab[k].op, dir_tab[k].timeout, dir_tab[k].handle);
		end
		// drain the short timers of the full pool with ticks
		repeat (70) drive_cmd(OP_TICK, 32'd0, 5'd0);

		// random part: mostly short timers and ticks so expiries occur
		for (int k = 0; k < 150; k++) begin
			idle_free = (k >= 100 && k < 140);
			kind = $urandom_range(99);
			n_live = 0;
			for (int i = 0; i < USABLE; i++) n_live += used_q[i];
			if (kind < 35) begin
				if ($urandom_range(9) == 0)
					tmo = $urandom;
				else if ($urandom_range(4) == 0)
					tmo = $urandom_range(2000);
				else
					tmo = $urandom_range(300);
				drive_cmd(OP_ADD, tmo, 5'($urandom));
			end else if (kind < 50) begin
				drive_cmd(OP_DEL, $urandom, 5'($urandom));
			end else if (kind < 95 || n_live == 0) begin
				drive_cmd(OP_TICK, $urandom, 5'($urandom));
			end else begin
				drive_cmd(OP_NOP, $urandom, 5'($urandom));
			end
		end
		s_tvalid <= 1'b0;
		idle_free = 1'b0;

		while (pending_q.size() != 0) @(posedge clk);
		repeat (100) @(posedge clk);
		$display("%0d commands issued, %0d result transfers checked, %0d timer expiries seen",
			items_sent, results_seen, expiries_seen);
		$display("adds, deletes, ticks and no-ops covered, with negative, full and bad-handle cases");
		if (mismatches == 0 && pending_q.size() == 0) begin
			$display("** hashed_timing_wheel_core: PASSED **");
		end else begin
			$display("%0d mismatches", mismatches);
			$display("** hashed_timing_wheel_core: FAILED **");
		end
		$finish;
	end
endmodule
`default_nettype wire
